[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath interface types for the
// text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Port field widths.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int CHAR_W      = 8;
  localparam int RCOL_W      = 7;
  localparam int RROW_W      = 6;
  localparam int COLOR_W     = 4;
  localparam int ATTR_W      = 16;
  localparam int CELL_W      = 32;
  localparam int CCOL_W      = 7;
  localparam int CROW_W      = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FG      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BG      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR    = 3'd4;

  localparam logic [7:0] COLUMNS_RST = 8'd80;
  localparam logic [6:0] ROWS_RST    = 7'd25;

  // Operations.
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Control codes.
  localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  localparam logic [CELL_W-1:0] BLANK_CELL = 32'h0000_0020;

  typedef struct packed {
    logic accept;     // latch the input item
    logic clr_full;   // blank one memory word of the power-up sweep
    logic clr_row;    // blank one word of the row leaving the top
    logic norm_init;  // start reducing the top-row pointer
    logic norm_step;  // one remainder step
    logic exec;       // read access or put update
    logic load_out;   // load the output register
  } tcw_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic norm_last;
    logic scroll;
    logic rows_written;
  } tcw_sts_t;

endpackage

[rtl/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the console: power-up sweep, top-pointer reduction after a
// row-count change, item execution, row clearing on scroll and hand-off to
// the output register.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_NORM,
    S_EXEC,
    S_SCROLL,
    S_RESP
  } state_t;

  state_t state;
  logic   out_valid;
  logic   norm_pend;

  assign s_tready = (state == S_IDLE) && !norm_pend;
  assign m_tvalid = out_valid;

  always_comb begin
    cmd           = '0;
    cmd.accept    = s_tvalid && s_tready;
    cmd.clr_full  = (state == S_CLEAR);
    cmd.norm_init = (state == S_IDLE) && norm_pend;
    cmd.norm_step = (state == S_NORM);
    cmd.exec      = (state == S_EXEC);
    cmd.clr_row   = (state == S_SCROLL);
    cmd.load_out  = (state == S_RESP) && (!out_valid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
      norm_pend <= 1'b0;
    end else begin
      // A new row count may leave the top pointer past the last row.
      if (sts.rows_written) begin
        norm_pend <= 1'b1;
      end else if (cmd.norm_init) begin
        norm_pend <= 1'b0;
      end

      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          if (sts.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (norm_pend) begin
            state <= S_NORM;
          end else if (cmd.accept) begin
            state <= S_EXEC;
          end
        end
        S_NORM: begin
          if (sts.norm_last) state <= S_IDLE;
        end
        S_EXEC: begin
          state <= sts.scroll ? S_SCROLL : S_RESP;
        end
        S_SCROLL: begin
          if (sts.clr_last) state <= S_RESP;
        end
        S_RESP: begin
          if (cmd.load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/tcw_dp.sv]
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath for the console: configuration registers, cursor and top-row
// pointer, the cell memory with its clearing counter, the remainder unit
// for the top pointer and the output register.
// ----------------------------------------------------------------------------
module tcw_dp #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64,
  parameter int TAB_STEP    = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tcw_pkg::tcw_cmd_t                  cmd,
  output tcw_pkg::tcw_sts_t                  sts,
  input  logic                               s_tuser,
  input  logic [tcw_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                               cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int TOP_W   = $clog2(MAX_ROWS);
  localparam int ADDR_W  = COL_W + TOP_W;
  localparam int CSUM_W  = $clog2(MAX_COLUMNS + TAB_STEP + 1);
  localparam int COLX_W  = (CSUM_W > tcw_pkg::RCOL_W) ? CSUM_W : tcw_pkg::RCOL_W;
  localparam int RSUM_W  = $clog2(2 * MAX_ROWS);
  localparam int ROWX_W  = (RSUM_W > tcw_pkg::RROW_W) ? RSUM_W : tcw_pkg::RROW_W;
  localparam int NCNT_W  = (TOP_W > 1) ? $clog2(TOP_W) : 1;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // Configuration registers.
  logic [7:0]                     cols_cfg;
  logic [6:0]                     rows_cfg;
  logic [tcw_pkg::COLOR_W-1:0]    fg_cfg;
  logic [tcw_pkg::COLOR_W-1:0]    bg_cfg;
  logic [tcw_pkg::ATTR_W-1:0]     attr_cfg;

  // Latched input item.
  logic                           in_op;
  logic [tcw_pkg::CHAR_W-1:0]     in_ch;
  logic [tcw_pkg::RCOL_W-1:0]     in_rc;
  logic [tcw_pkg::RROW_W-1:0]     in_rr;

  // Console state.
  logic [COL_W-1:0]               cur_col;
  logic [TOP_W-1:0]               cur_line;
  logic [TOP_W-1:0]               top;
  logic [TOP_W-1:0]               top_raw;
  logic                           bell_r;

  // Clearing counter and remainder unit.
  logic [ADDR_W-1:0]              clr_cnt;
  logic [ROWX_W-1:0]              norm_rem;
  logic [NCNT_W-1:0]              norm_cnt;

  // Cell memory.
  logic [tcw_pkg::CELL_W-1:0]     mem [MEM_DEPTH];
  logic [tcw_pkg::CELL_W-1:0]     rdata;
  logic                           rd_blank;

  // Output register.
  logic [tcw_pkg::CELL_W-1:0]     out_cell;
  logic [tcw_pkg::CCOL_W-1:0]     out_col;
  logic [tcw_pkg::CROW_W-1:0]     out_row;
  logic                           out_bell;

  // Combinational values.
  logic [COLX_W-1:0]              eff_cols;
  logic [ROWX_W-1:0]              eff_rows;
  logic [COLX_W-1:0]              colx;
  logic [ROWX_W-1:0]              linex;
  logic [COLX_W-1:0]              col_a;
  logic [COLX_W-1:0]              col_b;
  logic [COLX_W-1:0]              wcol;
  logic [ROWX_W-1:0]              line_a;
  logic [ROWX_W-1:0]              line_b;
  logic                           line_inc;
  logic                           bell_c;
  logic                           scroll_c;
  logic                           put_wr;
  logic [tcw_pkg::CELL_W-1:0]     put_data;
  logic [COLX_W-1:0]              csel;
  logic [ROWX_W-1:0]              rsel;
  logic [ROWX_W-1:0]              prow_sum;
  logic [ROWX_W-1:0]              prow;
  logic                           in_bounds;
  logic [ADDR_W-1:0]              acc_addr;
  logic [ROWX_W-1:0]              rem_shift;
  logic [ROWX_W-1:0]              rem_new;
  logic [ROWX_W-1:0]              top_inc;
  logic                           mem_we;
  logic [ADDR_W-1:0]              mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]     mem_wdata;
  logic                           mem_re;

  // Size registers: zero counts as one, large values saturate.
  always_comb begin
    if (cols_cfg == '0) begin
      eff_cols = COLX_W'(1);
    end else if (32'(cols_cfg) > 32'(MAX_COLUMNS)) begin
      eff_cols = COLX_W'(MAX_COLUMNS);
    end else begin
      eff_cols = COLX_W'(cols_cfg);
    end
    if (rows_cfg == '0) begin
      eff_rows = ROWX_W'(1);
    end else if (32'(rows_cfg) > 32'(MAX_ROWS)) begin
      eff_rows = ROWX_W'(MAX_ROWS);
    end else begin
      eff_rows = ROWX_W'(rows_cfg);
    end
  end

  assign colx  = COLX_W'(cur_col);
  assign linex = ROWX_W'(cur_line);

  // Cursor update for a put.
  always_comb begin
    col_a    = colx;
    line_inc = 1'b0;
    bell_c   = 1'b0;
    put_wr   = 1'b0;
    put_data = tcw_pkg::BLANK_CELL;
    case (in_ch)
      tcw_pkg::CH_LF: begin
        col_a    = '0;
        line_inc = 1'b1;
      end
      tcw_pkg::CH_CR: begin
        col_a = '0;
      end
      tcw_pkg::CH_TAB: begin
        col_a = colx + COLX_W'(TAB_STEP);
      end
      tcw_pkg::CH_BEL: begin
        bell_c = 1'b1;
      end
      tcw_pkg::CH_BS: begin
        col_a  = (colx == '0) ? '0 : colx - COLX_W'(1);
        put_wr = 1'b1;
      end
      default: begin
        col_a    = colx + COLX_W'(1);
        put_wr   = 1'b1;
        put_data = {attr_cfg, bg_cfg, fg_cfg, in_ch};
      end
    endcase

    wcol = (in_ch == tcw_pkg::CH_BS) ? col_a : colx;

    if (col_a >= eff_cols) begin
      col_b    = '0;
      line_inc = 1'b1;
    end else begin
      col_b = col_a;
    end

    line_a = linex + ROWX_W'(line_inc);
    if (line_a >= eff_rows) begin
      scroll_c = 1'b1;
      line_b   = eff_rows - ROWX_W'(1);
    end else begin
      scroll_c = 1'b0;
      line_b   = line_a;
    end
  end

  // Visible cell to ring address; the sum stays below twice the row count.
  assign csel      = (in_op == tcw_pkg::OP_READ) ? COLX_W'(in_rc) : wcol;
  assign rsel      = (in_op == tcw_pkg::OP_READ) ? ROWX_W'(in_rr) : linex;
  assign in_bounds = (csel < eff_cols) && (rsel < eff_rows);
  assign prow_sum  = ROWX_W'(top) + rsel;
  assign prow      = (prow_sum >= eff_rows) ? prow_sum - eff_rows : prow_sum;
  assign acc_addr  = {prow[TOP_W-1:0], csel[COL_W-1:0]};

  // One restoring remainder step of top modulo the row count.
  assign rem_shift = {norm_rem[ROWX_W-2:0], top[TOP_W-1]};
  assign rem_new   = (rem_shift >= eff_rows) ? rem_shift - eff_rows : rem_shift;
  assign top_inc   = ROWX_W'(top) + ROWX_W'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = acc_addr;
    mem_wdata = tcw_pkg::BLANK_CELL;
    if (cmd.clr_full) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
    end else if (cmd.clr_row) begin
      mem_we    = 1'b1;
      mem_waddr = {top, clr_cnt[COL_W-1:0]};
    end else if (cmd.exec && (in_op == tcw_pkg::OP_PUT) && put_wr && in_bounds) begin
      mem_we    = 1'b1;
      mem_wdata = put_data;
    end
  end

  assign mem_re = cmd.exec && (in_op == tcw_pkg::OP_READ) && in_bounds;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[acc_addr];
  end

  always_comb begin
    sts.rows_written = cfg_we && (cfg_index == tcw_pkg::CFG_ROWS);
    sts.scroll       = (in_op == tcw_pkg::OP_PUT) && scroll_c;
    sts.norm_last    = (norm_cnt == NCNT_W'(TOP_W - 1));
    sts.clr_last     = cmd.clr_row ? (&clr_cnt[COL_W-1:0]) : (&clr_cnt);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_cfg <= tcw_pkg::COLUMNS_RST;
      rows_cfg <= tcw_pkg::ROWS_RST;
      fg_cfg   <= '0;
      bg_cfg   <= '0;
      attr_cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcw_pkg::CFG_COLUMNS: cols_cfg <= cfg_wdata[7:0];
        tcw_pkg::CFG_ROWS:    rows_cfg <= cfg_wdata[6:0];
        tcw_pkg::CFG_FG:      fg_cfg   <= cfg_wdata[tcw_pkg::COLOR_W-1:0];
        tcw_pkg::CFG_BG:      bg_cfg   <= cfg_wdata[tcw_pkg::COLOR_W-1:0];
        tcw_pkg::CFG_ATTR:    attr_cfg <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input latch and output register.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_op <= s_tuser;
      in_ch <= s_tdata[7:0];
      in_rc <= s_tdata[14:8];
      in_rr <= s_tdata[20:15];
    end
    if (cmd.exec) begin
      rd_blank <= !in_bounds;
    end
    if (cmd.load_out) begin
      if (in_op == tcw_pkg::OP_READ) begin
        out_cell <= rd_blank ? tcw_pkg::BLANK_CELL : rdata;
        out_bell <= 1'b0;
      end else begin
        out_cell <= '0;
        out_bell <= bell_r;
      end
      out_col <= tcw_pkg::CCOL_W'(cur_col);
      out_row <= tcw_pkg::CROW_W'(cur_line);
    end
  end

  // Cursor, top pointer and sequencing counters. top_raw keeps the pointer
  // as the last scroll left it; top is that value reduced by the current
  // row count, so a later row count is always reduced from top_raw.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col  <= '0;
      cur_line <= '0;
      top      <= '0;
      top_raw  <= '0;
      bell_r   <= 1'b0;
      clr_cnt  <= '0;
      norm_rem <= '0;
      norm_cnt <= '0;
    end else begin
      if (cmd.exec) begin
        bell_r <= (in_op == tcw_pkg::OP_PUT) && bell_c;
        if (in_op == tcw_pkg::OP_PUT) begin
          cur_col  <= col_b[COL_W-1:0];
          cur_line <= line_b[TOP_W-1:0];
        end
      end

      if (cmd.clr_full || cmd.clr_row) begin
        clr_cnt <= sts.clr_last ? '0 : clr_cnt + ADDR_W'(1);
      end
      // The old top row has been blanked; the next row becomes the top.
      if (cmd.clr_row && sts.clr_last) begin
        top     <= (top_inc == eff_rows) ? '0 : top_inc[TOP_W-1:0];
        top_raw <= (top_inc == eff_rows) ? '0 : top_inc[TOP_W-1:0];
      end

      if (cmd.norm_init) begin
        norm_rem <= '0;
        norm_cnt <= '0;
        top      <= top_raw;
      end else if (cmd.norm_step) begin
        norm_rem <= rem_new;
        norm_cnt <= norm_cnt + NCNT_W'(1);
        if (sts.norm_last) begin
          top <= rem_new[TOP_W-1:0];
        end else begin
          top <= top << 1;
        end
      end
    end
  end

  assign m_tdata = {2'b00, out_bell, out_row, out_col, out_cell};

endmodule

[rtl/text_console_character_writer_top.sv]
// ----------------------------------------------------------------------------
// text_console_character_writer_top
// Character-cell console with a cursor, a ring of rows and a cell memory.
//
//   Channel   Direction  Handshake          Payload
//   s_*       in         tvalid/tready      tuser: operation; tdata: character,
//                                           read column, read row
//   m_*       out        tvalid/tready      cell fields, cursor, bell
//   cfg_*     in         write enable only  register index and value
//
// A read or an ordinary put goes through accept, memory access and output
// register load. A put that scrolls adds a step in which the row leaving
// the top is blanked one word per cycle on the write port. After reset the
// whole memory, 8192 words by default, is blanked before the first item is
// taken. A change of the row count is followed by a top-pointer reduction
// before the next item is taken. A stalled output holds the block in its
// last step.
// ----------------------------------------------------------------------------
module text_console_character_writer_top #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64,
  parameter int TAB_STEP    = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic                            s_tuser,   // operation
  // character [7:0], read column [14:8], read row [20:15]
  input  logic [tcw_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // character [7:0], foreground [11:8], background [15:12],
  // attributes [31:16], cursor column [38:32], cursor row [44:39], bell [45]
  output logic [tcw_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  tcw_pkg::tcw_cmd_t cmd;
  tcw_pkg::tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcw_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .TAB_STEP    (TAB_STEP)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

[rtl/tcw_checker.sv]
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the console, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tcw_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [tcw_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The memory sweep after reset keeps the input closed.
  a_reset_closed: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input open right after reset");

  // Items are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input open while an item is in progress");

  // A bell comes only from a put, whose cell fields are zero.
  a_bell_no_cell: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[45] |-> m_tdata[31:0] == 32'h0)
    else $error("bell result carries cell data");

endmodule

bind text_console_character_writer_top tcw_checker u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer testbench
// Streams puts and cell reads into the console and checks every result
// against a cycle-free model of the screen, the row ring and the cursor,
// or the literal values of known steps. A short script of directed steps
// runs first, followed by random phases under several screen sizes and
// colour settings. Both stream sides stall at random except in calm phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int COLS_MAX = 128;
  localparam int ROWS_MAX = 64;
  localparam int TAB_COLS = 4;
  localparam int LIMIT    = 1000000;

  typedef struct packed {
    logic [7:0]  character;
    logic [3:0]  foreground;
    logic [3:0]  background;
    logic [15:0] attributes;
    logic [6:0]  column;
    logic [5:0]  row;
    logic        bell;
  } cell_result_t;

  typedef enum logic [1:0] {STEP_PREDICTED, STEP_KNOWN, STEP_SETUP} step_kind_t;

  typedef struct packed {
    step_kind_t   kind;
    logic         op;
    logic [7:0]   ch;
    logic [6:0]   rc;
    logic [5:0]   rr;
    cell_result_t want;
    logic [7:0]   cols;
    logic [6:0]   rows;
    logic [3:0]   fg;
    logic [3:0]   bg;
    logic [15:0]  attr;
  } script_row_t;

  typedef struct packed {
    logic [7:0]  cols;
    logic [6:0]  rows;
    logic [3:0]  fg;
    logic [3:0]  bg;
    logic [15:0] attr;
    logic [15:0] count;
    logic        calm;
  } phase_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic                            s_tuser = 1'b0;
  logic [tcw_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [tcw_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            cfg_we = 1'b0;
  logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Screen model: ring rows of COLS_MAX cells, as the block stores them.
  logic [31:0] screen [COLS_MAX*ROWS_MAX];
  int          top_ptr;
  int          cur_col;
  int          cur_line;
  logic [7:0]  cols_reg;
  logic [6:0]  rows_reg;
  logic [3:0]  fg_reg;
  logic [3:0]  bg_reg;
  logic [15:0] attr_reg;

  cell_result_t pending [$];
  script_row_t  script [$];
  phase_t       phase_plan [8];
  logic [7:0]   codes [5] = '{tcw_pkg::CH_LF, tcw_pkg::CH_CR, tcw_pkg::CH_TAB,
                              tcw_pkg::CH_BEL, tcw_pkg::CH_BS};
  string        field_name [7] = '{"character", "foreground", "background",
                                   "attributes", "cursor column", "cursor row",
                                   "bell"};
  int           errors = 0;
  int           cycle_count = 0;
  int           hold_off = 0;
  bit           calm = 1'b0;

  text_console_character_writer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int vis_cols();
    int c;
    c = int'(cols_reg);
    if (c == 0) c = 1;
    if (c > COLS_MAX) c = COLS_MAX;
    return c;
  endfunction

  function automatic int vis_rows();
    int r;
    r = int'(rows_reg);
    if (r == 0) r = 1;
    if (r > ROWS_MAX) r = ROWS_MAX;
    return r;
  endfunction

  function automatic int ring_index(int col, int row);
    return (((top_ptr % vis_rows()) + row) % vis_rows()) * COLS_MAX + col;
  endfunction

  function automatic void put_cell(int col, int row, logic [31:0] value);
    if (col >= vis_cols() || row >= vis_rows()) return;
    screen[ring_index(col, row)] = value;
  endfunction

  // A cursor at or below the bottom scrolls once: the old top row is blanked
  // and becomes the new bottom row.
  function automatic void check_bottom();
    int rows;
    int old_top;
    rows = vis_rows();
    if (cur_line >= rows) begin
      old_top = top_ptr % rows;
      for (int i = 0; i < COLS_MAX; i++) begin
        screen[old_top*COLS_MAX + i] = tcw_pkg::BLANK_CELL;
      end
      top_ptr = (old_top + 1) % rows;
      cur_line = rows - 1;
    end
  endfunction

  function automatic cell_result_t console_step(logic op, logic [7:0] ch,
                                                logic [6:0] rc, logic [5:0] rr);
    cell_result_t r;
    logic [31:0]  cval;
    r = '0;
    cval = '0;
    if (op == tcw_pkg::OP_READ) begin
      if (int'(rc) < vis_cols() && int'(rr) < vis_rows()) begin
        cval = screen[ring_index(int'(rc), int'(rr))];
      end else begin
        cval = tcw_pkg::BLANK_CELL;
      end
    end else begin
      case (ch)
        tcw_pkg::CH_LF: begin
          cur_line++;
          cur_col = 0;
          check_bottom();
        end
        tcw_pkg::CH_CR:  cur_col = 0;
        tcw_pkg::CH_TAB: cur_col += TAB_COLS;
        tcw_pkg::CH_BEL: r.bell = 1'b1;
        tcw_pkg::CH_BS: begin
          if (cur_col > 0) cur_col--;
          put_cell(cur_col, cur_line, tcw_pkg::BLANK_CELL);
        end
        default: begin
          put_cell(cur_col, cur_line, {attr_reg, bg_reg, fg_reg, ch});
          cur_col++;
        end
      endcase
      if (cur_col >= vis_cols()) begin
        cur_col = 0;
        cur_line++;
      end
      check_bottom();
    end
    r.character  = cval[7:0];
    r.foreground = cval[11:8];
    r.background = cval[15:12];
    r.attributes = cval[31:16];
    r.column     = cur_col[6:0];
    r.row        = cur_line[5:0];
    return r;
  endfunction

  function automatic script_row_t guess_step(logic op, logic [7:0] ch,
                                             logic [6:0] rc, logic [5:0] rr);
    script_row_t s;
    s = '0;
    s.kind = STEP_PREDICTED;
    s.op = op;
    s.ch = ch;
    s.rc = rc;
    s.rr = rr;
    return s;
  endfunction

  function automatic script_row_t known_step(logic op, logic [7:0] ch, logic [6:0] rc,
                                             logic [5:0] rr, logic [7:0] cchar,
                                             logic [3:0] fg, logic [3:0] bg,
                                             logic [15:0] attr, logic [6:0] col,
                                             logic [5:0] row, logic bell);
    script_row_t s;
    s = guess_step(op, ch, rc, rr);
    s.kind = STEP_KNOWN;
    s.want = '{cchar, fg, bg, attr, col, row, bell};
    return s;
  endfunction

  function automatic script_row_t setup_step(logic [7:0] c, logic [6:0] r, logic [3:0] f,
                                             logic [3:0] b, logic [15:0] a);
    script_row_t s;
    s = '0;
    s.kind = STEP_SETUP;
    s.cols = c;
    s.rows = r;
    s.fg = f;
    s.bg = b;
    s.attr = a;
    return s;
  endfunction

  // Waits for the console to drain, then writes every register.
  task automatic apply_setup(logic [7:0] c, logic [6:0] r, logic [3:0] f,
                             logic [3:0] b, logic [15:0] a);
    logic [15:0]                   value [5];
    logic [tcw_pkg::CFG_IDX_W-1:0] reg_idx [5];
    value = '{{8'h00, c}, {9'h000, r}, {12'h000, f}, {12'h000, b}, a};
    reg_idx = '{tcw_pkg::CFG_COLUMNS, tcw_pkg::CFG_ROWS, tcw_pkg::CFG_FG,
                tcw_pkg::CFG_BG, tcw_pkg::CFG_ATTR};
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx[i];
      cfg_wdata <= value[i];
      case (reg_idx[i])
        tcw_pkg::CFG_COLUMNS: cols_reg = value[i][7:0];
        tcw_pkg::CFG_ROWS:    rows_reg = value[i][6:0];
        tcw_pkg::CFG_FG:      fg_reg = value[i][3:0];
        tcw_pkg::CFG_BG:      bg_reg = value[i][3:0];
        tcw_pkg::CFG_ATTR:    attr_reg = value[i];
        default: ;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(logic op, logic [7:0] ch, logic [6:0] rc, logic [5:0] rr,
                           bit known, cell_result_t lit);
    int           gap;
    cell_result_t guess;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, rr, rc, ch};
    do @(posedge clk); while (!s_tready);
    guess = console_step(op, ch, rc, rr);
    pending.push_back(known ? lit : guess);
  endtask

  // Output side stalls in bursts of random length.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_off <= 0;
    end else if (hold_off != 0) begin
      hold_off <= hold_off - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      hold_off <= $urandom_range(0, 7);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    cell_result_t want;
    int           want_f [7];
    int           got_f [7];
    if (!rst && m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, m_tdata);
        errors++;
      end else begin
        want = pending.pop_front();
        want_f = '{want.character, want.foreground, want.background, want.attributes,
                   want.column, want.row, want.bell};
        got_f = '{m_tdata[7:0], m_tdata[11:8], m_tdata[15:12], m_tdata[31:16],
                  m_tdata[38:32], m_tdata[44:39], m_tdata[45]};
        for (int i = 0; i < 7; i++) begin
          if (want_f[i] != got_f[i]) begin
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, field_name[i], want_f[i], got_f[i]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic       op;
    logic [7:0] ch;
    logic [6:0] rc;
    logic [5:0] rr;
    int         pick;

    for (int i = 0; i < COLS_MAX*ROWS_MAX; i++) screen[i] = tcw_pkg::BLANK_CELL;
    top_ptr  = 0;
    cur_col  = 0;
    cur_line = 0;
    cols_reg = tcw_pkg::COLUMNS_RST;
    rows_reg = tcw_pkg::ROWS_RST;
    fg_reg   = '0;
    bg_reg   = '0;
    attr_reg = '0;

    // Directed script. The first steps run on the reset screen of 80 x 25.
    script.push_back(known_step(tcw_pkg::OP_READ, 8'h00, 7'd0, 6'd0,
                                8'h20, 0, 0, 0, 0, 0, 0));
    script.push_back(known_step(tcw_pkg::OP_READ, 8'h00, 7'd127, 6'd63,
                                8'h20, 0, 0, 0, 0, 0, 0));
    script.push_back(known_step(tcw_pkg::OP_PUT, 8'hFF, 7'd0, 6'd0,
                                8'h00, 0, 0, 0, 1, 0, 0));
    script.push_back(known_step(tcw_pkg::OP_PUT, 8'h00, 7'd0, 6'd0,
                                8'h00, 0, 0, 0, 2, 0, 0));
    script.push_back(known_step(tcw_pkg::OP_READ, 8'h00, 7'd0, 6'd0,
                                8'hFF, 0, 0, 0, 2, 0, 0));
    script.push_back(known_step(tcw_pkg::OP_PUT, tcw_pkg::CH_BEL, 7'd0, 6'd0,
                                8'h00, 0, 0, 0, 2, 0, 1));
    script.push_back(known_step(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 7'd0, 6'd0,
                                8'h00, 0, 0, 0, 6, 0, 0));
    script.push_back(known_step(tcw_pkg::OP_PUT, tcw_pkg::CH_CR, 7'd0, 6'd0,
                                8'h00, 0, 0, 0, 0, 0, 0));
    // Backspace at column 0 stays there and blanks the cell under the cursor.
    script.push_back(known_step(tcw_pkg::OP_PUT, tcw_pkg::CH_BS, 7'd0, 6'd0,
                                8'h00, 0, 0, 0, 0, 0, 0));
    script.push_back(known_step(tcw_pkg::OP_READ, 8'h00, 7'd0, 6'd0,
                                8'h20, 0, 0, 0, 0, 0, 0));
    script.push_back(known_step(tcw_pkg::OP_PUT, tcw_pkg::CH_LF, 7'd0, 6'd0,
                                8'h00, 0, 0, 0, 0, 1, 0));
    // On a 2 x 2 screen the second character wraps past the bottom and scrolls.
    script.push_back(setup_step(8'd2, 7'd2, 4'hF, 4'hF, 16'hFFFF));
    script.push_back(known_step(tcw_pkg::OP_PUT, 8'h78, 7'd0, 6'd0,
                                8'h00, 0, 0, 0, 1, 1, 0));
    script.push_back(known_step(tcw_pkg::OP_PUT, 8'h79, 7'd0, 6'd0,
                                8'h00, 0, 0, 0, 0, 1, 0));
    script.push_back(known_step(tcw_pkg::OP_READ, 8'h00, 7'd0, 6'd0,
                                8'h78, 4'hF, 4'hF, 16'hFFFF, 0, 1, 0));
    script.push_back(known_step(tcw_pkg::OP_READ, 8'h00, 7'd1, 6'd1,
                                8'h20, 0, 0, 0, 0, 1, 0));
    script.push_back(guess_step(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 7'd0, 6'd0));
    // Zero sizes count as one, which leaves the cursor below the screen.
    script.push_back(setup_step(8'd0, 7'd0, 4'h1, 4'h2, 16'h8001));
    script.push_back(guess_step(tcw_pkg::OP_READ, 8'h00, 7'd0, 6'd0));
    script.push_back(guess_step(tcw_pkg::OP_PUT, 8'h7A, 7'd0, 6'd0));
    // Oversized registers saturate at the largest screen.
    script.push_back(setup_step(8'd255, 7'd127, 4'h0, 4'h0, 16'h0000));
    script.push_back(guess_step(tcw_pkg::OP_PUT, tcw_pkg::CH_LF, 7'd0, 6'd0));
    script.push_back(guess_step(tcw_pkg::OP_READ, 8'h00, 7'd127, 6'd63));
    script.push_back(guess_step(tcw_pkg::OP_PUT, 8'h7E, 7'd0, 6'd0));
    script.push_back(guess_step(tcw_pkg::OP_READ, 8'h00, 7'd0, 6'd0));

    phase_plan = '{
      '{8'd8,   7'd4,   4'hF, 4'h0, 16'hFFFF, 16'd120, 1'b0},
      '{8'd128, 7'd64,  4'h0, 4'hF, 16'h0000, 16'd150, 1'b0},
      '{8'd0,   7'd0,   4'h5, 4'hA, 16'h5A3C, 16'd60,  1'b0},
      '{8'd255, 7'd127, 4'h9, 4'h6, 16'hC381, 16'd100, 1'b1},
      '{8'd3,   7'd2,   4'h3, 4'hC, 16'h0F0F, 16'd100, 1'b0},
      '{8'd1,   7'd1,   4'hE, 4'h1, 16'hF0F0, 16'd40,  1'b0},
      '{8'd40,  7'd10,  4'h7, 4'h8, 16'h1234, 16'd130, 1'b0},
      // Shrinks the screen under a cursor that is likely outside the new size.
      '{8'd6,   7'd3,   4'hB, 4'h4, 16'hA5A5, 16'd80,  1'b1}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      case (script[i].kind)
        STEP_SETUP: apply_setup(script[i].cols, script[i].rows, script[i].fg,
                                script[i].bg, script[i].attr);
        STEP_KNOWN: send_item(script[i].op, script[i].ch, script[i].rc, script[i].rr,
                              1'b1, script[i].want);
        default:    send_item(script[i].op, script[i].ch, script[i].rc, script[i].rr,
                              1'b0, '0);
      endcase
    end

    for (int p = 0; p < 8; p++) begin
      apply_setup(phase_plan[p].cols, phase_plan[p].rows, phase_plan[p].fg,
                  phase_plan[p].bg, phase_plan[p].attr);
      calm = phase_plan[p].calm;
      repeat (phase_plan[p].count) begin
        ch = 8'($urandom_range(0, 255));
        rc = 7'($urandom_range(0, 127));
        rr = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 9) < 3) begin
          op = tcw_pkg::OP_READ;
          // Most reads land on the visible screen; the rest go anywhere.
          if ($urandom_range(0, 3) != 0) begin
            rc = 7'($urandom_range(0, vis_cols() - 1));
            rr = 6'($urandom_range(0, vis_rows() - 1));
          end
        end else begin
          op = tcw_pkg::OP_PUT;
          pick = $urandom_range(0, 19);
          if (pick < 13) ch = 8'($urandom_range(8'h20, 8'h7E));
          else if (pick < 17) ch = codes[$urandom_range(0, 4)];
        end
        send_item(op, ch, rc, rr, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/tcw_pkg.sv
rtl/tcw_ctrl.sv
rtl/tcw_dp.sv
rtl/text_console_character_writer_top.sv
rtl/tcw_checker.sv
tb/testbench.sv
